// ===== rtl/obm_pkg.sv =====
package obm_pkg;

   localparam int TIMER_BITS_DEFAULT = 10;
   localparam int CFG_WIDTH = 10;
   localparam int CFG_COUNT = 8;
   localparam int CFG_INDEX_BITS = 3;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      CFG_RESET_LOW      = 3'd0,
      CFG_PRESENCE_SAMPLE = 3'd1,
      CFG_RESET_TAIL     = 3'd2,
      CFG_ZERO_LOW       = 3'd3,
      CFG_ONE_LOW        = 3'd4,
      CFG_READ_LOW       = 3'd5,
      CFG_READ_SAMPLE    = 3'd6,
      CFG_SLOT_TAIL      = 3'd7
   } cfg_index_type;

   typedef logic [CFG_WIDTH-1:0] cfg_word_type;
   typedef cfg_word_type [CFG_COUNT-1:0] cfg_bank_type;

   localparam cfg_bank_type CFG_RESET_VALUES = {
      10'd80, 10'd5, 10'd1, 10'd5, 10'd75, 10'd500, 10'd115, 10'd500
   };

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_RESET = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_RLOW  = 4'd1,
      PH_RWAIT = 4'd2,
      PH_REDGE = 4'd3,
      PH_RTAIL = 4'd4,
      PH_SLOW  = 4'd5,
      PH_SWAIT = 4'd6,
      PH_SEDGE = 4'd7,
      PH_STAIL = 4'd8
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       line_in;
   } item_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_byte;
   } result_type;

endpackage

// ===== rtl/obm_if.sv =====
interface obm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_byte;
   logic       line_in;

   modport source (output valid, output action, output data_byte, output line_in,
                   input ready);
   modport sink (input valid, input action, input data_byte, input line_in,
                 output ready);
endinterface

interface obm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       presence;
   logic [7:0] read_byte;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence, output read_byte, input ready);
   modport sink (input valid, input drive_low, input busy_res, input done_res,
                 input presence, input read_byte, output ready);
endinterface

interface obm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [obm_pkg::CFG_INDEX_BITS-1:0] index;
   logic [obm_pkg::CFG_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/one_wire_bus_master_top.sv =====
// Each request is held in the request register, then its result in the response register.
// Throughput: one request per cycle, set by the single-pass tick logic between the request
// register and the response register; a response held by the receiver stops intake once the
// request register is also full.
// Reset: synchronous, active high; clears the bus state, the registers return to their
// reset timings, and both pipeline stages are emptied.
module one_wire_bus_master_top #(
   parameter int TIMER_BITS = obm_pkg::TIMER_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   obm_req_if.sink   req_chan,
   obm_rsp_if.source rsp_chan,
   obm_csr_if.sink   csr_chan
);

   obm_pkg::cfg_bank_type cfg;
   obm_pkg::item_type     item_ff, item_in;
   obm_pkg::result_type   result_ff, core_result;
   logic                  in_valid_ff, out_valid_ff;
   logic                  out_free, fire, core_idle;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign fire = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   assign item_in.action = req_chan.action;
   assign item_in.data_byte = req_chan.data_byte;
   assign item_in.line_in = req_chan.line_in;

   obm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   obm_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (core_result),
      .idle   (core_idle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            out_valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff <= item_in;
      end
      if (fire) begin
         result_ff <= core_result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.drive_low = result_ff.drive_low;
   assign rsp_chan.busy_res = result_ff.busy_res;
   assign rsp_chan.done_res = result_ff.done_res;
   assign rsp_chan.presence = result_ff.presence;
   assign rsp_chan.read_byte = result_ff.read_byte;

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> rsp_chan.busy_res)
      else $error("completion reported without busy");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.drive_low |-> rsp_chan.busy_res)
      else $error("line driven low while idle");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      fire && core_result.done_res |=> core_idle)
      else $error("bus engine not idle after completion");

   a_result_taken: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_chan.valid)
      else $error("response lost after a processed tick");

endmodule

// ===== rtl/obm_csr.sv =====
module obm_csr (
   input  logic                  clock,
   input  logic                  reset,
   obm_csr_if.sink               csr_chan,
   output obm_pkg::cfg_bank_type cfg
);

   obm_pkg::cfg_bank_type cfg_ff;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= obm_pkg::CFG_RESET_VALUES;
      end else if (csr_chan.valid) begin
         cfg_ff[csr_chan.index] <= csr_chan.data;
      end
   end

endmodule

// ===== rtl/obm_core.sv =====
module obm_core #(
   parameter int TIMER_BITS = obm_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  obm_pkg::item_type     item,
   input  obm_pkg::cfg_bank_type cfg,
   output obm_pkg::result_type   result,
   output logic                  idle
);

   localparam int TMAX = (1 << TIMER_BITS) - 1;
   localparam int WIDE = (TIMER_BITS > obm_pkg::CFG_WIDTH) ? TIMER_BITS : obm_pkg::CFG_WIDTH;

   obm_pkg::phase_type    phase_ff, phase_in, phase_s, phase_succ;
   logic [TIMER_BITS-1:0] timer_ff, timer_in, timer_s, timer_inc, phase_len;
   logic [2:0]            bit_ff, bit_in, bit_s;
   logic [7:0]            shift_ff, shift_in, shift_s, shift_cap;
   logic                  is_read_ff, is_read_in, is_read_s;
   logic                  presence_ff, presence_in;
   logic [7:0]            received_ff, received_in;
   logic                  start, expire, op_end, slot;

   function automatic logic [TIMER_BITS-1:0] cap_count(input obm_pkg::cfg_word_type v);
      logic [WIDE-1:0] w;
      w = WIDE'(v);
      if (w > WIDE'(TMAX)) begin
         cap_count = TIMER_BITS'(TMAX);
      end else begin
         cap_count = w[TIMER_BITS-1:0];
      end
   endfunction

   // Start of a command merged into the working state, phase timing and successor.
   always_comb begin
      start = (phase_ff == obm_pkg::PH_IDLE) && (item.action != obm_pkg::ACT_NONE);
      phase_s = phase_ff;
      timer_s = timer_ff;
      bit_s = bit_ff;
      shift_s = shift_ff;
      is_read_s = is_read_ff;
      if (start) begin
         timer_s = '0;
         bit_s = 3'd0;
         if (item.action == obm_pkg::ACT_RESET) begin
            phase_s = obm_pkg::PH_RLOW;
         end else begin
            is_read_s = (item.action == obm_pkg::ACT_READ);
            shift_s = is_read_s ? 8'd0 : item.data_byte;
            phase_s = obm_pkg::PH_SLOW;
         end
      end

      shift_cap = shift_s;
      if (phase_s == obm_pkg::PH_SEDGE && is_read_s) begin
         shift_cap[bit_s] = shift_s[bit_s] | item.line_in;
      end

      case (phase_s)
         obm_pkg::PH_RLOW:  phase_len = cap_count(cfg[obm_pkg::CFG_RESET_LOW]);
         obm_pkg::PH_RWAIT: phase_len = cap_count(cfg[obm_pkg::CFG_PRESENCE_SAMPLE]);
         obm_pkg::PH_RTAIL: phase_len = cap_count(cfg[obm_pkg::CFG_RESET_TAIL]);
         obm_pkg::PH_SLOW: begin
            if (is_read_s) begin
               phase_len = cap_count(cfg[obm_pkg::CFG_READ_LOW]);
            end else if (shift_s[bit_s]) begin
               phase_len = cap_count(cfg[obm_pkg::CFG_ONE_LOW]);
            end else begin
               phase_len = cap_count(cfg[obm_pkg::CFG_ZERO_LOW]);
            end
         end
         obm_pkg::PH_SWAIT: phase_len = is_read_s ? cap_count(cfg[obm_pkg::CFG_READ_SAMPLE])
                                                  : '0;
         obm_pkg::PH_STAIL: phase_len = cap_count(cfg[obm_pkg::CFG_SLOT_TAIL]);
         default:           phase_len = TIMER_BITS'(1);
      endcase

      timer_inc = timer_s + TIMER_BITS'(1);
      expire = (phase_s != obm_pkg::PH_IDLE) && ((timer_inc >= phase_len) || (timer_inc == '0));

      op_end = 1'b0;
      phase_succ = obm_pkg::PH_IDLE;
      case (phase_s)
         obm_pkg::PH_RLOW: begin
            phase_succ = (cfg[obm_pkg::CFG_PRESENCE_SAMPLE] != '0) ? obm_pkg::PH_RWAIT
                                                                   : obm_pkg::PH_REDGE;
         end
         obm_pkg::PH_RWAIT: phase_succ = obm_pkg::PH_REDGE;
         obm_pkg::PH_REDGE: begin
            if (cfg[obm_pkg::CFG_RESET_TAIL] != '0) begin
               phase_succ = obm_pkg::PH_RTAIL;
            end else begin
               op_end = 1'b1;
            end
         end
         obm_pkg::PH_SLOW: begin
            phase_succ = (is_read_s && cfg[obm_pkg::CFG_READ_SAMPLE] != '0) ? obm_pkg::PH_SWAIT
                                                                           : obm_pkg::PH_SEDGE;
         end
         obm_pkg::PH_SWAIT: phase_succ = obm_pkg::PH_SEDGE;
         obm_pkg::PH_SEDGE: begin
            if (cfg[obm_pkg::CFG_SLOT_TAIL] != '0) begin
               phase_succ = obm_pkg::PH_STAIL;
            end else begin
               op_end = 1'b1;
            end
         end
         default: op_end = 1'b1;
      endcase

      slot = (phase_s inside {[obm_pkg::PH_SLOW:obm_pkg::PH_STAIL]});
   end

   // Next state.
   always_comb begin
      phase_in = phase_s;
      timer_in = timer_s;
      bit_in = bit_s;
      shift_in = shift_cap;
      is_read_in = is_read_s;
      if (phase_s != obm_pkg::PH_IDLE) begin
         timer_in = timer_inc;
         if (expire) begin
            timer_in = '0;
            if (!op_end) begin
               phase_in = phase_succ;
            end else if (slot && bit_s != 3'd7) begin
               bit_in = bit_s + 3'd1;
               phase_in = obm_pkg::PH_SLOW;
            end else begin
               bit_in = 3'd0;
               phase_in = obm_pkg::PH_IDLE;
            end
         end
      end
   end

   // Outputs.
   always_comb begin
      presence_in = presence_ff;
      received_in = received_ff;
      if (phase_s == obm_pkg::PH_REDGE) begin
         presence_in = !item.line_in;
      end
      if (expire && op_end && slot && bit_s == 3'd7 && is_read_s) begin
         received_in = shift_cap;
      end
      result.busy_res = (phase_s != obm_pkg::PH_IDLE);
      result.drive_low = (phase_s == obm_pkg::PH_RLOW) || (phase_s == obm_pkg::PH_SLOW);
      result.done_res = expire && op_end && !(slot && bit_s != 3'd7);
      result.presence = presence_in;
      result.read_byte = received_in;
   end

   assign idle = (phase_ff == obm_pkg::PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= obm_pkg::PH_IDLE;
         timer_ff <= '0;
         bit_ff <= 3'd0;
         shift_ff <= 8'd0;
         is_read_ff <= 1'b0;
         presence_ff <= 1'b0;
         received_ff <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         bit_ff <= bit_in;
         shift_ff <= shift_in;
         is_read_ff <= is_read_in;
         presence_ff <= presence_in;
         received_ff <= received_in;
      end
   end

endmodule
